// ===== rtl/bse_pkg.sv =====
// Shared types, constants and register codes for the bit-plane extractor.
`default_nettype none
package bse_pkg;

    localparam int unsigned PixelWidth = 8;
    localparam int unsigned PlaneWidth = 3;
    localparam int unsigned CountWidth = 24;
    localparam int unsigned PadWidth   = 16;
    localparam int unsigned ColWidth   = 16;
    localparam int unsigned BitCntWidth = 3;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

    // Register reset values
    localparam logic [PlaneWidth-1:0] PlaneBitReset   = 3'd7;
    localparam logic                  TakeEveryReset  = 1'b1;
    localparam logic                  AnalyseReset    = 1'b0;
    localparam logic [PadWidth-1:0]   PadBytesReset   = 16'd0;
    localparam logic [ColWidth-1:0]   ImageWidthReset = 16'd1;

    // Configuration register indexes
    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_PLANE_BIT   = 3'd0,
        CFG_TAKE_EVERY  = 3'd1,
        CFG_ANALYSE     = 3'd2,
        CFG_PAD_BYTES   = 3'd3,
        CFG_IMAGE_WIDTH = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PlaneWidth-1:0] plane_bit;
        logic                  take_every_pixel;
        logic                  analyse_mode;
        logic [PadWidth-1:0]   pad_bytes;
        logic [ColWidth-1:0]   image_width;
    } cfg_t;

    typedef struct packed {
        logic                  byte_valid;
        logic [PixelWidth-1:0] data_byte;
        logic [CountWidth-1:0] zero_total;
        logic [CountWidth-1:0] one_total;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/bse_cfg.sv =====
// Configuration register bank for the bit-plane extractor.
`default_nettype none
module bse_cfg
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [bse_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  wire logic [bse_pkg::CfgDataWidth-1:0]     cfg_data,
    output bse_pkg::cfg_t                             cfg
);

    bse_pkg::cfg_t cfg_reg;
    bse_pkg::cfg_t cfg_next;

    // Decode a write request into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bse_pkg::CFG_PLANE_BIT:
                    cfg_next.plane_bit = cfg_data[bse_pkg::PlaneWidth-1:0];
                bse_pkg::CFG_TAKE_EVERY:
                    cfg_next.take_every_pixel = cfg_data[0];
                bse_pkg::CFG_ANALYSE:
                    cfg_next.analyse_mode = cfg_data[0];
                bse_pkg::CFG_PAD_BYTES:
                    cfg_next.pad_bytes = cfg_data[bse_pkg::PadWidth-1:0];
                bse_pkg::CFG_IMAGE_WIDTH:
                    cfg_next.image_width = cfg_data[bse_pkg::ColWidth-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plane_bit        <= bse_pkg::PlaneBitReset;
            cfg_reg.take_every_pixel <= bse_pkg::TakeEveryReset;
            cfg_reg.analyse_mode     <= bse_pkg::AnalyseReset;
            cfg_reg.pad_bytes        <= bse_pkg::PadBytesReset;
            cfg_reg.image_width      <= bse_pkg::ImageWidthReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/bse_core.sv =====
// Extraction state and combinational per-pixel update logic.
`default_nettype none
module bse_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic [bse_pkg::PixelWidth-1:0]    pixel,
    input  wire logic                              image_start,
    input  wire bse_pkg::cfg_t                     cfg,
    output bse_pkg::result_t                       result
);

    logic [bse_pkg::ColWidth-1:0]    column_reg, column_next;
    logic                            past_row_reg, past_row_next;
    logic [bse_pkg::PixelWidth-1:0]  row_first_reg, row_first_next;
    logic [bse_pkg::PixelWidth-1:0]  prev_colour_reg, prev_colour_next;
    logic                            skipped_last_reg, skipped_last_next;
    logic [bse_pkg::PixelWidth-1:0]  shift_byte_reg, shift_byte_next;
    logic [bse_pkg::BitCntWidth-1:0] bits_in_byte_reg, bits_in_byte_next;
    logic [bse_pkg::PadWidth-1:0]    pad_left_reg, pad_left_next;
    logic [bse_pkg::CountWidth-1:0]  zero_count_reg, zero_count_next;
    logic [bse_pkg::CountWidth-1:0]  one_count_reg, one_count_next;

    // State as seen by this pixel, after an image start clears it
    logic [bse_pkg::ColWidth-1:0]    column_cur;
    logic                            past_row_cur;
    logic [bse_pkg::PixelWidth-1:0]  row_first_cur;
    logic [bse_pkg::PixelWidth-1:0]  prev_colour_cur;
    logic                            skipped_last_cur;
    logic [bse_pkg::PixelWidth-1:0]  shift_byte_cur;
    logic [bse_pkg::BitCntWidth-1:0] bits_in_byte_cur;
    logic [bse_pkg::PadWidth-1:0]    pad_left_cur;
    logic [bse_pkg::CountWidth-1:0]  zero_count_cur;
    logic [bse_pkg::CountWidth-1:0]  one_count_cur;

    logic [bse_pkg::PixelWidth-1:0]  carrier;
    logic [bse_pkg::PixelWidth-1:0]  colour;
    logic                            hidden_bit;
    logic                            col_zero;
    logic [bse_pkg::PixelWidth-1:0]  compare_colour;
    logic                            eligible;
    logic                            take_bit;
    logic                            byte_done;
    logic                            pad_done;
    logic [bse_pkg::ColWidth-1:0]    column_inc;

    // Clear the working state at the start of an image
    always_comb
    begin
        if (image_start)
        begin
            column_cur       = '0;
            past_row_cur     = 1'b0;
            row_first_cur    = '0;
            prev_colour_cur  = '0;
            skipped_last_cur = 1'b0;
            shift_byte_cur   = '0;
            bits_in_byte_cur = '0;
            pad_left_cur     = cfg.pad_bytes;
            zero_count_cur   = '0;
            one_count_cur    = '0;
        end
        else
        begin
            column_cur       = column_reg;
            past_row_cur     = past_row_reg;
            row_first_cur    = row_first_reg;
            prev_colour_cur  = prev_colour_reg;
            skipped_last_cur = skipped_last_reg;
            shift_byte_cur   = shift_byte_reg;
            bits_in_byte_cur = bits_in_byte_reg;
            pad_left_cur     = pad_left_reg;
            zero_count_cur   = zero_count_reg;
            one_count_cur    = one_count_reg;
        end
    end

    // Split the pixel into carrier bit and remaining colour
    assign carrier    = bse_pkg::PixelWidth'(1) << cfg.plane_bit;
    assign colour     = pixel & ~carrier;
    assign hidden_bit = |(pixel & carrier);

    // A row's first pixel compares with the first pixel of the row above
    assign col_zero       = (column_cur == '0);
    assign compare_colour = (col_zero && past_row_cur) ? row_first_cur : prev_colour_cur;
    assign row_first_next = col_zero ? colour : row_first_cur;

    assign eligible = cfg.take_every_pixel ||
                      ((colour != compare_colour) && (!col_zero || past_row_cur));
    assign take_bit  = eligible && !skipped_last_cur;
    assign byte_done = take_bit && (bits_in_byte_cur == {bse_pkg::BitCntWidth{1'b1}});
    assign pad_done  = (pad_left_cur == '0);

    // Shift, count and pack the taken bit
    always_comb
    begin
        skipped_last_next = eligible ? 1'b0 : 1'b1;
        shift_byte_next   = shift_byte_cur;
        bits_in_byte_next = bits_in_byte_cur;
        pad_left_next     = pad_left_cur;
        zero_count_next   = zero_count_cur;
        one_count_next    = one_count_cur;
        result.byte_valid = 1'b0;
        result.data_byte  = '0;

        if (take_bit)
        begin
            shift_byte_next   = {shift_byte_cur[bse_pkg::PixelWidth-2:0], hidden_bit};
            bits_in_byte_next = bits_in_byte_cur + 1'b1;
            if (cfg.analyse_mode && pad_done)
            begin
                if (hidden_bit)
                begin
                    if (one_count_cur != bse_pkg::CountMax)
                        one_count_next = one_count_cur + 1'b1;
                end
                else
                begin
                    if (zero_count_cur != bse_pkg::CountMax)
                        zero_count_next = zero_count_cur + 1'b1;
                end
            end
            if (byte_done)
            begin
                if (pad_done)
                begin
                    if (!cfg.analyse_mode)
                    begin
                        result.byte_valid = 1'b1;
                        result.data_byte  = shift_byte_next;
                    end
                end
                else
                begin
                    pad_left_next = pad_left_cur - 1'b1;
                end
                shift_byte_next = '0;
            end
        end

        result.zero_total = zero_count_next;
        result.one_total  = one_count_next;
    end

    // Advance the column and wrap at the row end
    assign column_inc       = column_cur + 1'b1;
    assign prev_colour_next = colour;

    always_comb
    begin
        column_next   = column_inc;
        past_row_next = past_row_cur;
        if ((column_inc >= cfg.image_width) || (column_inc == '0))
        begin
            column_next   = '0;
            past_row_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg       <= '0;
            past_row_reg     <= 1'b0;
            row_first_reg    <= '0;
            prev_colour_reg  <= '0;
            skipped_last_reg <= 1'b0;
            shift_byte_reg   <= '0;
            bits_in_byte_reg <= '0;
            pad_left_reg     <= '0;
            zero_count_reg   <= '0;
            one_count_reg    <= '0;
        end
        else if (advance)
        begin
            column_reg       <= column_next;
            past_row_reg     <= past_row_next;
            row_first_reg    <= row_first_next;
            prev_colour_reg  <= prev_colour_next;
            skipped_last_reg <= skipped_last_next;
            shift_byte_reg   <= shift_byte_next;
            bits_in_byte_reg <= bits_in_byte_next;
            pad_left_reg     <= pad_left_next;
            zero_count_reg   <= zero_count_next;
            one_count_reg    <= one_count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bitplane_stego_extractor.sv =====
// Top level of the bit-plane hidden-data extractor: request registers and wiring.
`default_nettype none
// Takes one palette-index pixel per request in raster order and returns exactly one
// result per pixel: byte_valid/data_byte when a hidden byte completes outside the pad
// bytes and analyse mode, and the saturating zero/one bit counts. Pixels are taken one
// per clock while the output side keeps up; each request passes an input register, the
// update logic against the extraction state, and an output register, from which its
// result is offered. The sustained rate is one pixel per cycle while the output side
// keeps up; the update of the extraction state sets it. Configuration writes are
// always ready and must only be issued while no pixel is in flight.
module bitplane_stego_extractor
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Pixel requests
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [bse_pkg::PixelWidth-1:0]      pixel,
    input  wire logic                                image_start,
    // Results
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     byte_valid,
    output logic [bse_pkg::PixelWidth-1:0]           data_byte,
    output logic [bse_pkg::CountWidth-1:0]           zero_total,
    output logic [bse_pkg::CountWidth-1:0]           one_total,
    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bse_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  wire logic [bse_pkg::CfgDataWidth-1:0]    cfg_data
);

    bse_pkg::cfg_t    cfg;
    bse_pkg::result_t result;

    logic                             s1_valid_reg, s1_valid_next;
    logic [bse_pkg::PixelWidth-1:0]   s1_pixel_reg;
    logic                             s1_start_reg;
    logic                             out_valid_reg, out_valid_next;
    bse_pkg::result_t                 out_res_reg;
    logic                             out_free;
    logic                             advance;
    logic                             in_take;

    assign cfg_ready = 1'b1;

    bse_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: move a request forward whenever the result register frees up
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
    assign out_valid_next = out_free ? advance : out_valid_reg;

    bse_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .pixel       (s1_pixel_reg),
        .image_start (s1_start_reg),
        .cfg         (cfg),
        .result      (result)
    );

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture request and result payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pixel_reg <= pixel;
            s1_start_reg <= image_start;
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_valid = out_res_reg.byte_valid;
    assign data_byte  = out_res_reg.data_byte;
    assign zero_total = out_res_reg.zero_total;
    assign one_total  = out_res_reg.one_total;

endmodule
`default_nettype wire
